// ===== src/smqps_pkg.sv =====
// Package: field widths, command and register codes, lane probe type.
`default_nettype none
package smqps_pkg;

  localparam int PORT_W    = 6;
  localparam int QLEN_W    = 16;
  localparam int PCOUNT_W  = 7;
  localparam int SCOUNT_W  = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;
  localparam int SAMPLE_INPUTS = 4;

  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_PACKET = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PORT_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 1'b1;

  localparam logic [PCOUNT_W-1:0] PORT_COUNT_RST   = 7'd0;
  localparam logic [SCOUNT_W-1:0] SAMPLE_COUNT_RST = 3'd2;

  typedef struct packed {
    logic              active;
    logic [PORT_W-1:0] port;
  } probe_t;

endpackage
`default_nettype wire

// ===== src/smqps_in_if.sv =====
// Interface: input channel carrying reports and packets.
`default_nettype none
interface smqps_in_if
  import smqps_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              command;
  logic [PORT_W-1:0] report_port;
  logic [QLEN_W-1:0] queue_length;
  logic [PORT_W-1:0] sample_0;
  logic [PORT_W-1:0] sample_1;
  logic [PORT_W-1:0] sample_2;
  logic [PORT_W-1:0] sample_3;

  modport source (
    output valid, command, report_port, queue_length,
    output sample_0, sample_1, sample_2, sample_3,
    input  ready
  );
  modport sink (
    input  valid, command, report_port, queue_length,
    input  sample_0, sample_1, sample_2, sample_3,
    output ready
  );
endinterface
`default_nettype wire

// ===== src/smqps_out_if.sv =====
// Interface: result channel carrying the port decision.
`default_nettype none
interface smqps_out_if
  import smqps_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              route_valid;
  logic [PORT_W-1:0] chosen_port;
  logic [QLEN_W-1:0] chosen_length;

  modport source (
    output valid, route_valid, chosen_port, chosen_length,
    input  ready
  );
  modport sink (
    input  valid, route_valid, chosen_port, chosen_length,
    output ready
  );
endinterface
`default_nettype wire

// ===== src/sampled_min_queue_port_selector.sv =====
// Top level: egress port selector with sampled lanes, memory lane and merge.
//
//  channel  dir  payload                                              handshake
//  item     in   command, report_port, queue_length, sample_0..3      valid/ready
//  result   out  route_valid, chosen_port, chosen_length              valid/ready
//  cfg      in   cfg_index, cfg_data (port_count, sample_count)       cfg_we
//
// A report writes every lane table copy; reports can follow back to back while no packet is in the lanes.
// A packet passes through a registered lane read of the table copies, then the merge into the
// result register; a new item is taken once the packet has left the lanes.
// Reset clears the table fill flags, memory slot, configuration and valid flags at once; no clearing pass.
// A stalled result holds in the output register; the lanes hold one packet behind it.
`default_nettype none
module sampled_min_queue_port_selector
  import smqps_pkg::*;
#(
  parameter int MAX_PORTS   = 64,
  parameter int MAX_SAMPLES = 4,
  parameter int LENGTH_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  smqps_in_if.sink                   item,
  smqps_out_if.source                result
);

  localparam int IDX_W = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
  localparam int SAMPLE_LANES = (MAX_SAMPLES < SAMPLE_INPUTS) ? MAX_SAMPLES : SAMPLE_INPUTS;
  localparam int LANES = SAMPLE_LANES + 1;
  localparam logic [32:0] LEN_MAX = (33'd1 << LENGTH_BITS) - 33'd1;

  logic [PCOUNT_W-1:0]    port_count;
  logic [SCOUNT_W-1:0]    sample_count;
  logic [PCOUNT_W-1:0]    ports_eff;
  logic [SCOUNT_W-1:0]    samples_eff;

  logic [MAX_PORTS-1:0]   filled;
  logic [PORT_W-1:0]      rem_port;
  logic                   mem_valid;
  logic                   s1_valid;

  logic                   accept;
  logic                   pkt_accept;
  logic                   rpt_accept;
  logic                   s1_adv;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic [LENGTH_BITS-1:0] wr_data;

  logic [PORT_W-1:0]      sample [SAMPLE_INPUTS];
  probe_t                 probe [LANES];
  probe_t                 cand [LANES];
  logic [LENGTH_BITS-1:0] cand_len [LANES];
  logic                   found;
  logic [PORT_W-1:0]      best_port;
  logic [LENGTH_BITS-1:0] best_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_count   <= PORT_COUNT_RST;
      sample_count <= SAMPLE_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PORT_COUNT:   port_count   <= cfg_data[PCOUNT_W-1:0];
        CFG_SAMPLE_COUNT: sample_count <= cfg_data[SCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ports_eff = port_count;
    if (32'(port_count) > MAX_PORTS) begin
      ports_eff = PCOUNT_W'(MAX_PORTS);
    end
    samples_eff = sample_count;
    if (32'(sample_count) > SAMPLE_LANES) begin
      samples_eff = SCOUNT_W'(SAMPLE_LANES);
    end
  end

  assign item.ready = !s1_valid;
  assign accept     = item.valid && item.ready;
  assign pkt_accept = accept && (item.command == CMD_PACKET);
  assign rpt_accept = accept && (item.command == CMD_REPORT);
  assign s1_adv     = s1_valid && (!result.valid || result.ready);

  assign wr_en   = rpt_accept && (32'(item.report_port) < MAX_PORTS);
  assign wr_idx  = IDX_W'(item.report_port);
  assign wr_data = (33'(item.queue_length) > LEN_MAX) ? LENGTH_BITS'(LEN_MAX)
                                                      : LENGTH_BITS'(item.queue_length);

  assign sample[0] = item.sample_0;
  assign sample[1] = item.sample_1;
  assign sample[2] = item.sample_2;
  assign sample[3] = item.sample_3;

  genvar g;
  generate
    for (g = 0; g < SAMPLE_LANES; g++) begin : g_sample_probe
      assign probe[g].port   = sample[g];
      assign probe[g].active = (32'(samples_eff) > g) &&
                               ({1'b0, sample[g]} < ports_eff);
    end
  endgenerate

  assign probe[SAMPLE_LANES].port   = rem_port;
  assign probe[SAMPLE_LANES].active = mem_valid && ({1'b0, rem_port} < ports_eff);

  generate
    for (g = 0; g < LANES; g++) begin : g_lane
      smqps_lane #(
        .MAX_PORTS   (MAX_PORTS),
        .LENGTH_BITS (LENGTH_BITS)
      ) u_lane (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_data  (wr_data),
        .filled   (filled),
        .rd_en    (pkt_accept),
        .probe    (probe[g]),
        .cand     (cand[g]),
        .cand_len (cand_len[g])
      );
    end
  endgenerate

  smqps_merge #(
    .LANES       (LANES),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_merge (
    .cand      (cand),
    .cand_len  (cand_len),
    .found     (found),
    .best_port (best_port),
    .best_len  (best_len)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (wr_en) begin
      filled[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pkt_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem_port  <= '0;
      mem_valid <= 1'b0;
    end else if (s1_adv && found) begin
      rem_port  <= best_port;
      mem_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_adv) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.route_valid   <= found;
      result.chosen_port   <= found ? best_port : '0;
      result.chosen_length <= found ? QLEN_W'(best_len) : '0;
    end
  end

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !item.ready)
    else $error("item taken while a packet is in the lanes");

  a_report_no_lane: assert property (@(posedge clk) disable iff (rst)
    rpt_accept |=> !s1_valid)
    else $error("report entered the lanes");

  a_memory_update: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && found) |=> (mem_valid && (rem_port == $past(best_port))))
    else $error("memory slot not updated with the chosen port");

  a_no_route_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.route_valid) |->
      ((result.chosen_port == '0) && (result.chosen_length == '0)))
    else $error("no-route result carries nonzero fields");

  a_port_in_range: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && found) |-> ({1'b0, best_port} < ports_eff))
    else $error("chosen port outside the ports in use");
`endif

endmodule
`default_nettype wire

// ===== src/smqps_lane.sv =====
// Lane: private copy of the queue length table with one registered read port.
`default_nettype none
module smqps_lane
  import smqps_pkg::*;
#(
  parameter int MAX_PORTS   = 64,
  parameter int LENGTH_BITS = 16,
  localparam int IDX_W = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [IDX_W-1:0]       wr_idx,
  input  wire logic [LENGTH_BITS-1:0] wr_data,
  input  wire logic [MAX_PORTS-1:0]   filled,
  input  wire logic                   rd_en,
  input  wire probe_t                 probe,
  output probe_t                      cand,
  output logic [LENGTH_BITS-1:0]      cand_len
);

  logic [LENGTH_BITS-1:0] mem [MAX_PORTS];
  logic [LENGTH_BITS-1:0] rd_q;
  logic                   set_q;
  logic [IDX_W-1:0]       rd_idx;

  assign rd_idx = IDX_W'(probe.port);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q  <= mem[rd_idx];
      set_q <= filled[rd_idx];
      cand  <= probe;
    end
  end

  assign cand_len = set_q ? rd_q : '0;

endmodule
`default_nettype wire

// ===== src/smqps_merge.sv =====
// Merge: pick the first lane with the strictly smallest queue length.
`default_nettype none
module smqps_merge
  import smqps_pkg::*;
#(
  parameter int LANES       = 5,
  parameter int LENGTH_BITS = 16
) (
  input  wire probe_t                 cand [LANES],
  input  wire logic [LENGTH_BITS-1:0] cand_len [LANES],
  output logic                        found,
  output logic [PORT_W-1:0]           best_port,
  output logic [LENGTH_BITS-1:0]      best_len
);

  always_comb begin
    found     = 1'b0;
    best_port = '0;
    best_len  = '0;
    for (int i = 0; i < LANES; i++) begin
      if (cand[i].active && (!found || (cand_len[i] < best_len))) begin
        found     = 1'b1;
        best_port = cand[i].port;
        best_len  = cand_len[i];
      end
    end
  end

endmodule
`default_nettype wire

// ===== dv/sampled_min_queue_port_selector_tb.sv =====
// Testbench: random and directed traffic against a predictor of the sampled min-queue selector.
`timescale 1ns / 1ps

import smqps_pkg::*;

typedef struct packed {
  logic                                 command;
  logic [PORT_W-1:0]                    report_port;
  logic [QLEN_W-1:0]                    queue_length;
  logic [SAMPLE_INPUTS-1:0][PORT_W-1:0] samples;
} item_t;

typedef struct packed {
  logic              route_valid;
  logic [PORT_W-1:0] chosen_port;
  logic [QLEN_W-1:0] chosen_length;
} choice_t;

class port_choice_board;
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned SAMPLE_LIMIT = 4;

  logic [QLEN_W-1:0]   lengths [TABLE_DEPTH];
  logic [PORT_W-1:0]   mem_port;
  bit                  mem_valid;
  logic [PCOUNT_W-1:0] port_count;
  logic [SCOUNT_W-1:0] sample_count;
  choice_t             pending_choices [$];
  int                  errors;
  int                  reports;
  int                  packets;
  int                  unrouted;

  function new();
    foreach (lengths[i]) lengths[i] = '0;
    mem_port     = '0;
    mem_valid    = 1'b0;
    port_count   = PORT_COUNT_RST;
    sample_count = SAMPLE_COUNT_RST;
    errors       = 0;
    reports      = 0;
    packets      = 0;
    unrouted     = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_PORT_COUNT:   port_count = data[PCOUNT_W-1:0];
      CFG_SAMPLE_COUNT: sample_count = data[SCOUNT_W-1:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return pending_choices.size();
  endfunction

  function void take_item(item_t it);
    int unsigned       ports;
    int unsigned       picks;
    int unsigned       port;
    bit                found;
    logic [PORT_W-1:0] best_port;
    logic [QLEN_W-1:0] best_len;
    choice_t           c;
    if (it.command == CMD_REPORT) begin
      lengths[it.report_port] = it.queue_length;
      reports++;
      return;
    end
    packets++;
    ports = (32'(port_count) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(port_count);
    picks = (32'(sample_count) > SAMPLE_LIMIT) ? SAMPLE_LIMIT : 32'(sample_count);
    if (picks > SAMPLE_INPUTS) picks = SAMPLE_INPUTS;
    found     = 1'b0;
    best_port = '0;
    best_len  = '0;
    for (int i = 0; i < picks; i++) begin
      port = 32'(it.samples[i[1:0]]);
      if (port < ports && (!found || lengths[PORT_W'(port)] < best_len)) begin
        found     = 1'b1;
        best_port = PORT_W'(port);
        best_len  = lengths[PORT_W'(port)];
      end
    end
    if (mem_valid && 32'(mem_port) < ports && (!found || lengths[mem_port] < best_len)) begin
      found     = 1'b1;
      best_port = mem_port;
      best_len  = lengths[mem_port];
    end
    if (found) begin
      mem_port  = best_port;
      mem_valid = 1'b1;
      c = '{1'b1, best_port, best_len};
    end else begin
      c = '{1'b0, '0, '0};
      unrouted++;
    end
    pending_choices = {pending_choices, c};
  endfunction

  function void check_choice(logic rv, logic [PORT_W-1:0] cp, logic [QLEN_W-1:0] cl);
    choice_t want;
    if (pending_choices.size() == 0) begin
      $error("unexpected transaction: route_valid %0d chosen_port %0d chosen_length %0d",
             rv, cp, cl);
      errors++;
      return;
    end
    want = pending_choices.pop_front();
    if (rv !== want.route_valid) begin
      $error("route_valid: expected %0d, actual %0d", want.route_valid, rv);
      errors++;
    end
    if (cp !== want.chosen_port) begin
      $error("chosen_port: expected %0d, actual %0d", want.chosen_port, cp);
      errors++;
    end
    if (cl !== want.chosen_length) begin
      $error("chosen_length: expected %0d, actual %0d", want.chosen_length, cl);
      errors++;
    end
  endfunction
endclass

module sampled_min_queue_port_selector_tb;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 100;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  smqps_in_if  item ();
  smqps_out_if result ();

  sampled_min_queue_port_selector dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .result    (result)
  );

  port_choice_board sb;
  bit hold_req;
  bit quiet;
  int settings;
  int unsigned port_counts   [PHASES] = '{64, 8, 1, 127, 0, 33, 64, 5, 100, 64};
  int unsigned sample_counts [PHASES] = '{4, 3, 1, 7, 2, 0, 2, 4, 1, 4};

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("sampled_min_queue_port_selector: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready)
      sb.check_choice(result.route_valid, result.chosen_port, result.chosen_length);
  end

  initial begin
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        result.ready = 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end else begin
        result.ready = 1'b1;
      end
    end
  end

  function automatic logic [PORT_W-1:0] pick_port(int unsigned span);
    if (span > 0 && $urandom_range(0, 3) != 0)
      return PORT_W'($urandom_range(0, span - 1));
    return PORT_W'($urandom_range(0, 63));
  endfunction

  function automatic item_t random_item(int unsigned ports);
    item_t       it;
    int unsigned span;
    span = (ports > 64) ? 64 : ports;
    it.command     = ($urandom_range(0, 1) != 0) ? CMD_PACKET : CMD_REPORT;
    it.report_port = pick_port(span);
    case ($urandom_range(0, 3))
      0:       it.queue_length = QLEN_W'($urandom_range(0, 16'hFFFF));
      1:       it.queue_length = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      default: it.queue_length = QLEN_W'($urandom_range(0, 7));
    endcase
    for (int i = 0; i < SAMPLE_INPUTS; i++) it.samples[i[1:0]] = pick_port(span);
    return it;
  endfunction

  function automatic item_t mk_report(int unsigned port, int unsigned len);
    item_t it;
    it = random_item(64);
    it.command      = CMD_REPORT;
    it.report_port  = PORT_W'(port);
    it.queue_length = QLEN_W'(len);
    return it;
  endfunction

  function automatic item_t mk_packet(int unsigned s0, int unsigned s1, int unsigned s2,
                                      int unsigned s3);
    item_t it;
    it = random_item(64);
    it.command = CMD_PACKET;
    it.samples = {PORT_W'(s3), PORT_W'(s2), PORT_W'(s1), PORT_W'(s0)};
    return it;
  endfunction

  task automatic send(input item_t it);
    @(negedge clk);
    item.valid        = 1'b1;
    item.command      = it.command;
    item.report_port  = it.report_port;
    item.queue_length = it.queue_length;
    item.sample_0     = it.samples[0];
    item.sample_1     = it.samples[1];
    item.sample_2     = it.samples[2];
    item.sample_3     = it.samples[3];
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    sb.take_item(it);
  endtask

  task automatic idle(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      item.valid = 1'b0;
    end
  endtask

  task automatic configure(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    @(negedge clk);
    item.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DATA_W'(data);
    sb.write_reg(idx, CFG_DATA_W'(data));
    settings++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    quiet = 1'b0;
    settings = 0;
    item.valid = 1'b0;
    item.command = CMD_REPORT;
    item.report_port = '0;
    item.queue_length = '0;
    item.sample_0 = '0;
    item.sample_1 = '0;
    item.sample_2 = '0;
    item.sample_3 = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send(mk_packet(0, 1, 2, 3));
    send(mk_report(0, 16'hFFFF));
    send(mk_report(63, 0));
    configure(CFG_PORT_COUNT, 64);
    configure(CFG_SAMPLE_COUNT, 4);
    send(mk_report(5, 100));
    send(mk_report(7, 100));
    send(mk_report(42, 16'h8000));
    send(mk_packet(0, 5, 7, 42));
    send(mk_packet(0, 63, 5, 7));
    send(mk_report(63, 16'hFFFF));
    send(mk_packet(7, 5, 0, 0));
    send(mk_packet(0, 0, 0, 0));
    configure(CFG_SAMPLE_COUNT, 0);
    send(mk_packet(1, 2, 3, 4));
    configure(CFG_PORT_COUNT, 6);
    send(mk_packet(10, 20, 30, 40));
    configure(CFG_SAMPLE_COUNT, 7);
    send(mk_packet(63, 6, 5, 0));
    configure(CFG_PORT_COUNT, 127);
    send(mk_packet(63, 62, 61, 60));
    configure(CFG_PORT_COUNT, 1);
    configure(CFG_SAMPLE_COUNT, 1);
    send(mk_packet(0, 1, 1, 1));
    send(mk_packet(1, 0, 0, 0));
    send(mk_report(1, 0));
    send(mk_packet(1, 1, 1, 1));

    for (int p = 0; p < PHASES; p++) begin
      configure(CFG_PORT_COUNT, port_counts[p]);
      configure(CFG_SAMPLE_COUNT, sample_counts[p]);
      quiet = (p == PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 20) hold_req = 1'b1;
        send(random_item(port_counts[p]));
        if (!quiet && $urandom_range(0, 7) == 0) idle($urandom_range(1, 19));
      end
    end

    @(negedge clk);
    item.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d queue reports and %0d packets, %0d of them without a route,",
             sb.reports, sb.packets, sb.unrouted);
    $display("across %0d register writes, a long result stall and random idling.", settings);
    if (sb.errors == 0)
      $display("sampled_min_queue_port_selector: match");
    else
      $display("sampled_min_queue_port_selector: mismatch");
    $finish;
  end
endmodule

// ===== sim.f =====
src/smqps_pkg.sv
src/smqps_in_if.sv
src/smqps_out_if.sv
src/smqps_lane.sv
src/smqps_merge.sv
src/sampled_min_queue_port_selector.sv
dv/sampled_min_queue_port_selector_tb.sv
